/* sv/lpct_pkg.sv */
// Shared types and constants for the lidar crop-box / rigid-transform unit.
// Point and result payload structs, register indexes and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpct_pkg;

  localparam int COORD_BITS     = 20;
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_W         = COEF_FRAC_BITS + 2;   // Q2.14
  localparam int INT_W          = 8;

  localparam int BOX_W  = 3 * COORD_BITS;               // packed x, y, z
  localparam int RAD_W  = 2 * COORD_BITS;
  localparam int ROW_W  = 3 * COEF_W;
  localparam int CFG_W  = BOX_W;
  localparam int CFG_IDX_W = 3;

  // row arithmetic widths
  localparam int PROD_W = COEF_W + COORD_BITS;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SHR_W  = ACC_W - COEF_FRAC_BITS;
  localparam int OFS_W  = SHR_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS     = 3'd6;

  // identity rotation after reset
  localparam logic [ROW_W-1:0] ROT_X_RST = ROW_W'(1) << COEF_FRAC_BITS;
  localparam logic [ROW_W-1:0] ROT_Y_RST = ROW_W'(1) << (COEF_W + COEF_FRAC_BITS);
  localparam logic [ROW_W-1:0] ROT_Z_RST = ROW_W'(1) << (2 * COEF_W + COEF_FRAC_BITS);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic signed [COORD_BITS-1:0] in_z;
    logic        [INT_W-1:0]      in_intensity;
    logic                         point_valid;
    logic                         last_in;
  } point_in_t;

  typedef struct packed {
    logic                         kept;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic        [INT_W-1:0]      out_intensity;
    logic                         last_out;
  } point_out_t;

endpackage

`default_nettype wire

/* sv/lidar_point_cropbox_transform_unit.sv */
// A request passes the input register, the product register and the result register
// in that order before its result is valid.
// Throughput: one point per cycle; the three-stage pipeline stalls only when the
// result register is full and not taken, empty stages are filled meanwhile.
// Reset: synchronous; clears all stage valids and loads the configuration
// registers with a box holding only the origin, zero radius, identity rotation, zero offset.
`timescale 1ns / 1ps
`default_nettype none

module lidar_point_cropbox_transform_unit
  import lpct_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire point_in_t            in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output point_out_t                out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // configuration registers
  logic [BOX_W-1:0] box_min;
  logic [BOX_W-1:0] box_max;
  logic [RAD_W-1:0] radius_sq;
  logic [ROW_W-1:0] rot_x;
  logic [ROW_W-1:0] rot_y;
  logic [ROW_W-1:0] rot_z;
  logic [BOX_W-1:0] translation;

  // pipeline
  logic                    v1;
  logic                    v2;
  point_in_t               p1;
  logic [INT_W-1:0]        intensity2;
  logic                    last2;
  logic                    en1;
  logic                    en2;
  logic                    en3;
  logic                    drop;
  logic signed [COORD_BITS-1:0] rx;
  logic signed [COORD_BITS-1:0] ry;
  logic signed [COORD_BITS-1:0] rz;
  point_out_t              out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min     <= '0;
      box_max     <= '0;
      radius_sq   <= '0;
      rot_x       <= ROT_X_RST;
      rot_y       <= ROT_Y_RST;
      rot_z       <= ROT_Z_RST;
      translation <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_MIN:   box_min     <= cfg_data[BOX_W-1:0];
        REG_BOX_MAX:   box_max     <= cfg_data[BOX_W-1:0];
        REG_RADIUS_SQ: radius_sq   <= cfg_data[RAD_W-1:0];
        REG_ROT_X:     rot_x       <= cfg_data[ROW_W-1:0];
        REG_ROT_Y:     rot_y       <= cfg_data[ROW_W-1:0];
        REG_ROT_Z:     rot_z       <= cfg_data[ROW_W-1:0];
        REG_TRANS:     translation <= cfg_data[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage moves on when the one after it is empty or moving
  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      p1 <= in_data;
    end
    if (en2 && v1) begin
      intensity2 <= p1.in_intensity;
      last2      <= p1.last_in;
    end
    if (en3 && v2) begin
      out_data <= out_next;
    end
  end

  lpct_filter u_filter (
    .clk       (clk),
    .load      (en2 && v1),
    .pt        (p1),
    .box_min   (box_min),
    .box_max   (box_max),
    .radius_sq (radius_sq),
    .drop      (drop)
  );

  lpct_row u_row_x (
    .clk    (clk),
    .load   (en2 && v1),
    .coefs  (rot_x),
    .x      (p1.in_x),
    .y      (p1.in_y),
    .z      (p1.in_z),
    .offset (translation[0*COORD_BITS +: COORD_BITS]),
    .result (rx)
  );

  lpct_row u_row_y (
    .clk    (clk),
    .load   (en2 && v1),
    .coefs  (rot_y),
    .x      (p1.in_x),
    .y      (p1.in_y),
    .z      (p1.in_z),
    .offset (translation[1*COORD_BITS +: COORD_BITS]),
    .result (ry)
  );

  lpct_row u_row_z (
    .clk    (clk),
    .load   (en2 && v1),
    .coefs  (rot_z),
    .x      (p1.in_x),
    .y      (p1.in_y),
    .z      (p1.in_z),
    .offset (translation[2*COORD_BITS +: COORD_BITS]),
    .result (rz)
  );

  // dropped points carry zero coordinates
  always_comb begin
    out_next.kept          = !drop;
    out_next.out_x         = drop ? '0 : rx;
    out_next.out_y         = drop ? '0 : ry;
    out_next.out_z         = drop ? '0 : rz;
    out_next.out_intensity = intensity2;
    out_next.last_out      = last2;
  end

`ifndef SYNTH
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.kept |->
      out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0)
    else $error("dropped point with nonzero coordinates");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !v2 |=> !out_valid)
    else $error("result appeared without a request behind it");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    v1 && en2 |=> v2)
    else $error("request lost between input and product stage");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !v1 && !v2)
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

/* sv/lpct_filter.sv */
// Crop-box and horizontal radius test for one point.
// Box compare and squares are registered; the radius compare follows the register.
// Depends on lpct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpct_filter
  import lpct_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             load,
  input  wire point_in_t        pt,
  input  wire logic [BOX_W-1:0] box_min,
  input  wire logic [BOX_W-1:0] box_max,
  input  wire logic [RAD_W-1:0] radius_sq,
  output logic                  drop
);

  logic signed [RAD_W-1:0] sq_x_next;
  logic signed [RAD_W-1:0] sq_y_next;
  logic                    in_box_next;
  logic        [RAD_W-1:0] sq_x;
  logic        [RAD_W-1:0] sq_y;
  logic                    in_box;
  logic                    pt_valid;
  logic        [RAD_W:0]   rsq;

  assign sq_x_next = pt.in_x * pt.in_x;
  assign sq_y_next = pt.in_y * pt.in_y;

  // inclusive on every axis; an inverted axis never matches
  assign in_box_next =
      (pt.in_x >= $signed(box_min[0*COORD_BITS +: COORD_BITS])) &&
      (pt.in_x <= $signed(box_max[0*COORD_BITS +: COORD_BITS])) &&
      (pt.in_y >= $signed(box_min[1*COORD_BITS +: COORD_BITS])) &&
      (pt.in_y <= $signed(box_max[1*COORD_BITS +: COORD_BITS])) &&
      (pt.in_z >= $signed(box_min[2*COORD_BITS +: COORD_BITS])) &&
      (pt.in_z <= $signed(box_max[2*COORD_BITS +: COORD_BITS]));

  always_ff @(posedge clk) begin
    if (load) begin
      sq_x     <= sq_x_next;
      sq_y     <= sq_y_next;
      in_box   <= in_box_next;
      pt_valid <= pt.point_valid;
    end
  end

  assign rsq  = {1'b0, sq_x} + {1'b0, sq_y};
  assign drop = !pt_valid || in_box || (rsq <= {1'b0, radius_sq});

endmodule

`default_nettype wire

/* sv/lpct_row.sv */
// One row of the rigid transform: three Q2.14 products, registered, then
// exact sum, floor shift, translation and saturation to COORD_BITS.
// Depends on lpct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpct_row
  import lpct_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         load,
  input  wire logic        [ROW_W-1:0]      coefs,
  input  wire logic signed [COORD_BITS-1:0] x,
  input  wire logic signed [COORD_BITS-1:0] y,
  input  wire logic signed [COORD_BITS-1:0] z,
  input  wire logic signed [COORD_BITS-1:0] offset,
  output logic signed [COORD_BITS-1:0]      result
);

  logic signed [PROD_W-1:0] prod_x_next;
  logic signed [PROD_W-1:0] prod_y_next;
  logic signed [PROD_W-1:0] prod_z_next;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_z;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SHR_W-1:0]  shr;
  logic signed [OFS_W-1:0]  sum;
  logic                     over_hi;
  logic                     over_lo;

  assign prod_x_next = $signed(coefs[0*COEF_W +: COEF_W]) * x;
  assign prod_y_next = $signed(coefs[1*COEF_W +: COEF_W]) * y;
  assign prod_z_next = $signed(coefs[2*COEF_W +: COEF_W]) * z;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_x <= prod_x_next;
      prod_y <= prod_y_next;
      prod_z <= prod_z_next;
    end
  end

  assign acc = ACC_W'(prod_x) + ACC_W'(prod_y) + ACC_W'(prod_z);
  // dropping the fraction bits of a two's complement value floors it
  assign shr = acc[ACC_W-1:COEF_FRAC_BITS];
  assign sum = OFS_W'(shr) + OFS_W'(offset);

  // out of range when the coordinate's sign bit or any bit above it disagrees with the sign
  assign over_hi = !sum[OFS_W-1] && (|sum[OFS_W-2:COORD_BITS-1]);
  assign over_lo = sum[OFS_W-1] && !(&sum[OFS_W-2:COORD_BITS-1]);

  always_comb begin
    if (over_hi) begin
      result = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (over_lo) begin
      result = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      result = sum[COORD_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

/* tb/sv/lpct_point_checker.sv */
`timescale 1ns / 1ps
// Point checker for the lidar crop-box / rigid-transform unit: tracks config writes,
// predicts the result of every accepted request and compares accepted results in order.
// Depends on lpct_pkg.

module lpct_point_checker
  import lpct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  point_in_t            in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  point_out_t           out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);

  logic [BOX_W-1:0] box_lo, box_hi, offset;
  logic [RAD_W-1:0] rad_sq;
  logic [ROW_W-1:0] rot_x, rot_y, rot_z;

  point_out_t pending_points[$];
  int         err_n = 0;

  assign fail_count = err_n;

  task automatic log_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_n++;
  endtask

  function automatic logic [COORD_BITS-1:0] row_out(input logic [ROW_W-1:0] row,
                                                    input point_in_t p,
                                                    input logic [COORD_BITS-1:0] ofs);
    longint signed acc, v, lim;
    longint signed crd[3];
    int i;
    crd[0] = longint'(p.in_x);
    crd[1] = longint'(p.in_y);
    crd[2] = longint'(p.in_z);
    acc = 0;
    for (i = 0; i < 3; i++)
      acc += longint'($signed(row[i*COEF_W +: COEF_W])) * crd[i];
    // floor division by 2^frac, then offset and clamp
    v = (acc >>> COEF_FRAC_BITS) + longint'($signed(ofs));
    lim = (longint'(1) << (COORD_BITS - 1)) - 1;
    if (v > lim) v = lim;
    else if (v < -lim - 1) v = -lim - 1;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic point_out_t crop_transform(input point_in_t p);
    point_out_t r;
    longint signed crd[3];
    longint signed lo, hi;
    longint unsigned ax, ay;
    bit inside_box, near;
    int i;
    crd[0] = longint'(p.in_x);
    crd[1] = longint'(p.in_y);
    crd[2] = longint'(p.in_z);
    inside_box = 1'b1;
    for (i = 0; i < 3; i++) begin
      lo = longint'($signed(box_lo[i*COORD_BITS +: COORD_BITS]));
      hi = longint'($signed(box_hi[i*COORD_BITS +: COORD_BITS]));
      if (crd[i] < lo || crd[i] > hi) inside_box = 1'b0;
    end
    ax = (crd[0] < 0) ? -crd[0] : crd[0];
    ay = (crd[1] < 0) ? -crd[1] : crd[1];
    near = (ax * ax + ay * ay) <= longint'(rad_sq);

    r = '0;
    r.out_intensity = p.in_intensity;
    r.last_out      = p.last_in;
    if (p.point_valid && !inside_box && !near) begin
      r.kept  = 1'b1;
      r.out_x = row_out(rot_x, p, offset[0 +: COORD_BITS]);
      r.out_y = row_out(rot_y, p, offset[COORD_BITS +: COORD_BITS]);
      r.out_z = row_out(rot_z, p, offset[2*COORD_BITS +: COORD_BITS]);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    point_out_t want;
    if (rst) begin
      box_lo = '0;
      box_hi = '0;
      rad_sq = '0;
      rot_x  = ROT_X_RST;
      rot_y  = ROT_Y_RST;
      rot_z  = ROT_Z_RST;
      offset = '0;
      pending_points.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BOX_MIN:   box_lo = cfg_data[BOX_W-1:0];
          REG_BOX_MAX:   box_hi = cfg_data[BOX_W-1:0];
          REG_RADIUS_SQ: rad_sq = cfg_data[RAD_W-1:0];
          REG_ROT_X:     rot_x  = cfg_data[ROW_W-1:0];
          REG_ROT_Y:     rot_y  = cfg_data[ROW_W-1:0];
          REG_ROT_Z:     rot_z  = cfg_data[ROW_W-1:0];
          REG_TRANS:     offset = cfg_data[BOX_W-1:0];
          default: ;  // unused index: write has no effect
        endcase
      end

      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          log_mismatch("result with no request outstanding");
        end else begin
          want = pending_points.pop_front();
          if (out_data.kept !== want.kept)
            log_mismatch($sformatf("kept got %b want %b", out_data.kept, want.kept));
          if (out_data.out_x !== want.out_x)
            log_mismatch($sformatf("out_x got %0d want %0d", out_data.out_x, want.out_x));
          if (out_data.out_y !== want.out_y)
            log_mismatch($sformatf("out_y got %0d want %0d", out_data.out_y, want.out_y));
          if (out_data.out_z !== want.out_z)
            log_mismatch($sformatf("out_z got %0d want %0d", out_data.out_z, want.out_z));
          if (out_data.out_intensity !== want.out_intensity)
            log_mismatch($sformatf("out_intensity got %0d want %0d",
                                   out_data.out_intensity, want.out_intensity));
          if (out_data.last_out !== want.last_out)
            log_mismatch($sformatf("last_out got %b want %b",
                                   out_data.last_out, want.last_out));
        end
      end

      if (in_valid && in_ready)
        pending_points = {pending_points, crop_transform(in_data)};
    end
    pending <= pending_points.size();
  end

endmodule

/* tb/sv/tb_lidar_point_cropbox_transform_unit.sv */
`timescale 1ns / 1ps
// Testbench top for lidar_point_cropbox_transform_unit: clock, reset, config phases and
// point requests with random idling; checking is done by lpct_point_checker.
// Depends on lpct_pkg, the unit and the checker.

module tb_lidar_point_cropbox_transform_unit;
  import lpct_pkg::*;

  // index past the last register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  point_in_t            in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  point_out_t           out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int fail_count;
  int pending;
  bit steady = 1'b0;

  // current box corners, used to aim points at the box faces
  int lo_edge[3];
  int hi_edge[3];

  lidar_point_cropbox_transform_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lpct_point_checker point_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 8);
  end

  initial begin
    #500000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [CFG_W-1:0] pack_coords(input int x, input int y, input int z);
    logic [COORD_BITS-1:0] px, py, pz;
    px = x[COORD_BITS-1:0];
    py = y[COORD_BITS-1:0];
    pz = z[COORD_BITS-1:0];
    return {pz, py, px};
  endfunction

  function automatic logic [CFG_W-1:0] pack_coefs(input int cx, input int cy, input int cz);
    logic [COEF_W-1:0] a, b, c;
    a = cx[COEF_W-1:0];
    b = cy[COEF_W-1:0];
    c = cz[COEF_W-1:0];
    return CFG_W'({c, b, a});
  endfunction

  function automatic point_in_t mk_point(input int x, input int y, input int z,
                                         input int inten, input bit pv, input bit last);
    point_in_t p;
    p.in_x         = x[COORD_BITS-1:0];
    p.in_y         = y[COORD_BITS-1:0];
    p.in_z         = z[COORD_BITS-1:0];
    p.in_intensity = inten[INT_W-1:0];
    p.point_valid  = pv;
    p.last_in      = last;
    return p;
  endfunction

  // random value of random magnitude
  function automatic int rand_coord();
    logic signed [COORD_BITS-1:0] v;
    v = COORD_BITS'($urandom);
    return int'(v) >>> $urandom_range(COORD_BITS - 1);
  endfunction

  function automatic int aim_axis(input int a);
    case ($urandom_range(4))
      0: return lo_edge[a] - 1;
      1: return lo_edge[a];
      2: return hi_edge[a];
      3: return hi_edge[a] + 1;
      default: return rand_coord();
    endcase
  endfunction

  function automatic point_in_t rand_point();
    int x, y, z, r;
    r = $urandom_range(99);
    if (r < 35) begin
      x = $urandom; y = $urandom; z = $urandom;
    end else if (r < 65) begin
      x = aim_axis(0); y = aim_axis(1); z = aim_axis(2);
    end else begin
      x = rand_coord(); y = rand_coord(); z = rand_coord();
    end
    return mk_point(x, y, z, $urandom, $urandom_range(99) < 92, $urandom_range(15) == 0);
  endfunction

  task automatic push_point(input point_in_t p);
    if (!steady && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] bmin, input logic [CFG_W-1:0] bmax,
                              input logic [CFG_W-1:0] rad, input logic [CFG_W-1:0] rx,
                              input logic [CFG_W-1:0] ry, input logic [CFG_W-1:0] rz,
                              input logic [CFG_W-1:0] tr);
    int a;
    write_reg(REG_BOX_MIN, bmin);
    write_reg(REG_BOX_MAX, bmax);
    write_reg(REG_RADIUS_SQ, rad);
    write_reg(REG_ROT_X, rx);
    write_reg(REG_ROT_Y, ry);
    write_reg(REG_ROT_Z, rz);
    write_reg(REG_TRANS, tr);
    cfg_we <= 1'b0;
    @(posedge clk);
    for (a = 0; a < 3; a++) begin
      lo_edge[a] = int'($signed(bmin[a*COORD_BITS +: COORD_BITS]));
      hi_edge[a] = int'($signed(bmax[a*COORD_BITS +: COORD_BITS]));
    end
  endtask

  task automatic random_setup(input int mode);
    logic [CFG_W-1:0] bmin, bmax, rad, rx, ry, rz, tr;
    int a, ctr, half;
    int lo[3], hi[3];
    case (mode)
      0: begin
        for (a = 0; a < 3; a++) begin
          ctr  = int'($urandom_range(262144)) - 131072;
          half = $urandom_range(32768, 1);
          lo[a] = ctr - half;
          hi[a] = ctr + half;
        end
        bmin = pack_coords(lo[0], lo[1], lo[2]);
        bmax = pack_coords(hi[0], hi[1], hi[2]);
        rad  = CFG_W'($urandom_range(32'h1000_0000));
        rx   = pack_coefs($urandom, $urandom, $urandom);
        ry   = pack_coefs($urandom, $urandom, $urandom);
        rz   = pack_coefs($urandom, $urandom, $urandom);
        tr   = pack_coords($urandom, $urandom, $urandom);
      end
      1: begin
        // box spans all of x and y, pinned at the top of z
        bmin = pack_coords(-524288, -524288, 524287);
        bmax = pack_coords(524287, 524287, 524287);
        rad  = '0;
        rx   = pack_coefs(32767, 32767, 32767);
        ry   = rx;
        rz   = rx;
        tr   = pack_coords(524287, 524287, 524287);
      end
      2: begin
        // inverted box on every axis
        bmin = pack_coords(524287, 524287, 524287);
        bmax = pack_coords(-524288, -524288, -524288);
        rad  = CFG_W'($urandom_range(65535));
        rx   = pack_coefs(-32768, -32768, -32768);
        ry   = rx;
        rz   = rx;
        tr   = pack_coords(-524288, -524288, -524288);
      end
      default: begin
        // random contents, garbage above each rotation row's width, radius at its maximum
        bmin = CFG_W'({$urandom, $urandom});
        bmax = CFG_W'({$urandom, $urandom});
        rad  = '1;
        rx   = CFG_W'({$urandom, $urandom});
        ry   = CFG_W'({$urandom, $urandom});
        rz   = CFG_W'({$urandom, $urandom});
        tr   = CFG_W'({$urandom, $urandom});
      end
    endcase
    program_regs(bmin, bmax, rad, rx, ry, rz, tr);
    if (mode == 3) begin
      // out-of-range index must leave the registers alone
      write_reg(REG_UNUSED, CFG_W'({$urandom, $urandom}));
      cfg_we <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    int modes[8];
    int ph, n, count;

    modes = '{0, 1, 2, 0, 3, 0, 2, 0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: box at the origin, zero radius, identity
    for (n = 0; n < 3; n++) begin
      lo_edge[n] = 0;
      hi_edge[n] = 0;
    end
    push_point(mk_point(0, 0, 0, 17, 1'b1, 1'b0));
    push_point(mk_point(1, 0, 0, 0, 1'b1, 1'b0));
    push_point(mk_point(0, 0, 5, 255, 1'b1, 1'b0));
    push_point(mk_point(-524288, 524287, -524288, 255, 1'b1, 1'b1));
    push_point(mk_point(524287, 524287, 524287, 0, 1'b1, 1'b0));
    push_point(mk_point(-524288, -524288, -524288, 128, 1'b1, 1'b1));
    push_point(mk_point(5, 5, 5, 99, 1'b0, 1'b0));
    settle();

    // small box, radius 5, axis swap with a tiny z term, large offsets
    program_regs(pack_coords(-100, -100, -100), pack_coords(100, 100, 100), 60'd25,
                 pack_coefs(0, -16384, 0), pack_coefs(16384, 0, 1),
                 pack_coefs(0, 0, -32768), pack_coords(1000, -1000, 524287));
    push_point(mk_point(100, 100, 100, 1, 1'b1, 1'b0));
    push_point(mk_point(-100, -100, -100, 2, 1'b1, 1'b0));
    push_point(mk_point(101, 0, 0, 3, 1'b1, 1'b0));
    push_point(mk_point(-101, 50, 50, 4, 1'b1, 1'b1));
    push_point(mk_point(3, 4, 200, 5, 1'b1, 1'b0));
    push_point(mk_point(-3, -4, 200, 6, 1'b1, 1'b0));
    push_point(mk_point(3, 5, 200, 7, 1'b1, 1'b0));
    push_point(mk_point(10, 0, -524288, 8, 1'b1, 1'b0));
    push_point(mk_point(200, 7, -1, 9, 1'b1, 1'b0));
    push_point(mk_point(200, 7, -16385, 10, 1'b1, 1'b0));
    push_point(mk_point(524287, -524288, 524287, 11, 1'b1, 1'b1));
    push_point(mk_point(-524288, 524287, -524288, 12, 1'b0, 1'b1));
    settle();

    for (ph = 0; ph < 8; ph++) begin
      steady = (ph == 3);
      random_setup(modes[ph]);
      count = (modes[ph] == 3) ? 50 : 115;
      for (n = 0; n < count; n++)
        push_point(rand_point());
      settle();
    end
    steady = 1'b0;

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
